@@ design/avr_pkg.sv @@
// Shared types, widths and constants of the arrowhead vertex rotator.
package avr_pkg;

    // Width of the vectoring datapath: a 17-bit difference scaled by 2^14, plus CORDIC growth.
    localparam int VEC_W = 34;
    // Width of the rotation datapath: a 12-bit offset scaled by 2^14, plus CORDIC growth.
    localparam int ROT_W = 29;
    localparam int ANG_W = 32;
    localparam int GUARD = 14;
    localparam int PROD_W = 60;
    localparam int GAIN_SHIFT = 44;
    localparam int ATAN_ENTRIES = 24;
    localparam int WING_PIXELS = 15;

    localparam logic [ANG_W-1:0] HALF_TURN = 32'h8000_0000;
    localparam logic signed [30:0] KINV_Q30 = 31'sd652032874;

    localparam logic [ANG_W-1:0] ATAN_TABLE [ATAN_ENTRIES] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861,
        32'd10430,     32'd5215,      32'd2608,      32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81
    };

    typedef struct packed {
        logic signed [VEC_W-1:0] x;
        logic signed [VEC_W-1:0] y;
        logic [ANG_W-1:0]        z;
        logic                    zero;
        logic signed [15:0]      gx;
        logic signed [15:0]      gy;
    } t_vec_data;

    typedef struct packed {
        logic signed [ROT_W-1:0] ax;
        logic signed [ROT_W-1:0] ay;
        logic signed [ROT_W-1:0] bx;
        logic signed [ROT_W-1:0] by;
        logic [ANG_W-1:0]        z;
        logic signed [15:0]      gx;
        logic signed [15:0]      gy;
    } t_rot_data;

endpackage

@@ design/avr_vec_cell.sv @@
// One CORDIC vectoring cell: a single micro-rotation towards the x axis.
module avr_vec_cell import avr_pkg::*; #(
    parameter int STAGE = 0
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_en,
    input  logic      i_valid,
    input  t_vec_data i_data,
    output logic      o_valid,
    output t_vec_data o_data
);

    logic signed [VEC_W-1:0] sx;
    logic signed [VEC_W-1:0] sy;
    t_vec_data n_data;
    t_vec_data r_data;
    logic      r_valid;

    always_comb begin
        sx = i_data.x >>> STAGE;
        sy = i_data.y >>> STAGE;
        n_data = i_data;
        if (!i_data.y[VEC_W-1]) begin
            n_data.x = i_data.x + sy;
            n_data.y = i_data.y - sx;
            n_data.z = i_data.z + ATAN_TABLE[STAGE];
        end else begin
            n_data.x = i_data.x - sy;
            n_data.y = i_data.y + sx;
            n_data.z = i_data.z - ATAN_TABLE[STAGE];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

@@ design/avr_rot_cell.sv @@
// One CORDIC rotation cell: turns both wing vectors by the same micro-angle.
module avr_rot_cell import avr_pkg::*; #(
    parameter int STAGE = 0
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_en,
    input  logic      i_valid,
    input  t_rot_data i_data,
    output logic      o_valid,
    output t_rot_data o_data
);

    logic signed [ROT_W-1:0] sax;
    logic signed [ROT_W-1:0] say;
    logic signed [ROT_W-1:0] sbx;
    logic signed [ROT_W-1:0] sby;
    t_rot_data n_data;
    t_rot_data r_data;
    logic      r_valid;

    always_comb begin
        sax = i_data.ax >>> STAGE;
        say = i_data.ay >>> STAGE;
        sbx = i_data.bx >>> STAGE;
        sby = i_data.by >>> STAGE;
        n_data = i_data;
        if (!i_data.z[ANG_W-1]) begin
            n_data.ax = i_data.ax - say;
            n_data.ay = i_data.ay + sax;
            n_data.bx = i_data.bx - sby;
            n_data.by = i_data.by + sbx;
            n_data.z  = i_data.z - ATAN_TABLE[STAGE];
        end else begin
            n_data.ax = i_data.ax + say;
            n_data.ay = i_data.ay - sax;
            n_data.bx = i_data.bx + sby;
            n_data.by = i_data.by - sbx;
            n_data.z  = i_data.z + ATAN_TABLE[STAGE];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

@@ design/avr_gain.sv @@
// Gain correction, goal offset and saturation, ending in the output register.
module avr_gain import avr_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  t_rot_data          i_data,
    input  logic               i_ready,
    output logic               o_en,
    output logic               o_valid,
    output logic signed [15:0] o_first_wing_x,
    output logic signed [15:0] o_first_wing_y,
    output logic signed [15:0] o_second_wing_x,
    output logic signed [15:0] o_second_wing_y
);

    localparam logic signed [PROD_W-1:0] ROUND_HALF =
        PROD_W'(64'sd1 <<< (GAIN_SHIFT - 1));

    logic                     en_mul;
    logic                     en_out;
    logic                     r_mul_valid;
    logic signed [PROD_W-1:0] r_pax;
    logic signed [PROD_W-1:0] r_pay;
    logic signed [PROD_W-1:0] r_pbx;
    logic signed [PROD_W-1:0] r_pby;
    logic signed [15:0]       r_gx;
    logic signed [15:0]       r_gy;
    logic                     r_out_valid;
    logic signed [15:0]       r_fx;
    logic signed [15:0]       r_fy;
    logic signed [15:0]       r_sx;
    logic signed [15:0]       r_sy;
    logic signed [15:0]       n_fx;
    logic signed [15:0]       n_fy;
    logic signed [15:0]       n_sx;
    logic signed [15:0]       n_sy;

    // Rounds the scaled product, adds the goal coordinate and clamps to 16 bits.
    function automatic logic signed [15:0] place(input logic signed [PROD_W-1:0] p,
                                                  input logic signed [15:0] g);
        logic signed [PROD_W-1:0] t;
        logic signed [16:0]       r;
        logic signed [16:0]       s;
        t = p + ROUND_HALF;
        r = {t[PROD_W-1], t[PROD_W-1 -: 16]};
        s = r + {g[15], g};
        if (s > 17'sd32767) begin
            place = 16'sh7FFF;
        end else if (s < -17'sd32768) begin
            place = 16'sh8000;
        end else begin
            place = s[15:0];
        end
    endfunction

    assign en_out = !r_out_valid || i_ready;
    assign en_mul = !r_mul_valid || en_out;
    assign o_en   = en_mul;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mul_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (en_mul) begin
                r_mul_valid <= i_valid;
            end
            if (en_out) begin
                r_out_valid <= r_mul_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_mul) begin
            r_pax <= PROD_W'(i_data.ax) * PROD_W'(KINV_Q30);
            r_pay <= PROD_W'(i_data.ay) * PROD_W'(KINV_Q30);
            r_pbx <= PROD_W'(i_data.bx) * PROD_W'(KINV_Q30);
            r_pby <= PROD_W'(i_data.by) * PROD_W'(KINV_Q30);
            r_gx  <= i_data.gx;
            r_gy  <= i_data.gy;
        end
    end

    always_comb begin
        n_fx = place(r_pax, r_gx);
        n_fy = place(r_pay, r_gy);
        n_sx = place(r_pbx, r_gx);
        n_sy = place(r_pby, r_gy);
    end

    always_ff @(posedge i_clk) begin
        if (en_out) begin
            r_fx <= n_fx;
            r_fy <= n_fy;
            r_sx <= n_sx;
            r_sy <= n_sy;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_first_wing_x  = r_fx;
    assign o_first_wing_y  = r_fy;
    assign o_second_wing_x = r_sx;
    assign o_second_wing_y = r_sy;

endmodule

@@ design/arrowhead_vertex_rotator_top.sv @@
// Arrowhead vertex rotator: finds the two wing vertices of an arrowhead drawn at a goal point.
//
// Input channel: i_valid / o_ready carry one transaction of goal and object coordinates
// (signed Q12.4). Output channel: o_valid / i_ready carry one transaction of the two wing
// vertices, goal + R(angle)*(-w,-w) and goal + R(angle)*(-w,+w), saturated to 16 bits.
// The APB port holds the single register, wing_offset at address 0 (Q8.4, 12 bits).
// A transaction passes 2*N + 2 registers from acceptance to o_valid, with N = min(CORDIC_STAGES, 24):
// namely N vectoring cells, N rotation cells, one multiplier stage and the output
// register. The default is 16 stages.
// Throughput is one transaction per cycle while the receiver takes results; each cell
// hands its contents to the next one every cycle in which it is enabled.
// When the receiver stalls, the output register holds its result and the cells behind it
// close up any gaps, so new transactions are still taken until the chain is full.
// Reset clears all valid flags and sets wing_offset to fifteen pixels; there is no
// clearing pass, so o_ready is high as soon as reset is released.
// The register should only be written while no transaction is in flight.
module arrowhead_vertex_rotator_top import avr_pkg::*; #(
    parameter int CORDIC_STAGES = 16,
    parameter int FRACTION_BITS = 4
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic signed [15:0] i_goal_x,
    input  logic signed [15:0] i_goal_y,
    input  logic signed [15:0] i_object_x,
    input  logic signed [15:0] i_object_y,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [15:0] o_first_wing_x,
    output logic signed [15:0] o_first_wing_y,
    output logic signed [15:0] o_second_wing_x,
    output logic signed [15:0] o_second_wing_y,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    localparam int STAGES = (CORDIC_STAGES > ATAN_ENTRIES) ? ATAN_ENTRIES : CORDIC_STAGES;
    localparam logic [11:0] WING_RESET = 12'((WING_PIXELS << FRACTION_BITS) & 'hFFF);
    localparam logic REG_WING_OFFSET = 1'b0;

    logic [11:0] r_wing;
    logic        reg_sel;

    t_vec_data   vec_in;
    t_vec_data   vec_q   [STAGES];
    logic        vec_v   [STAGES];
    logic        vec_en  [STAGES];
    t_rot_data   rot_in;
    t_rot_data   rot_q   [STAGES];
    logic        rot_v   [STAGES];
    logic        rot_en  [STAGES];
    logic        gain_en;

    logic signed [16:0]      dx;
    logic signed [16:0]      dy;
    logic signed [VEC_W-1:0] sx;
    logic signed [VEC_W-1:0] sy;
    logic [ANG_W-1:0]        ang;
    logic                    flip;
    logic signed [ROT_W-1:0] wv;

    // Configuration port.
    assign reg_sel = (paddr[2] == REG_WING_OFFSET);
    assign pready  = 1'b1;
    assign prdata  = reg_sel ? {20'd0, r_wing} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wing <= WING_RESET;
        end else if (psel && penable && pwrite && reg_sel) begin
            r_wing <= pwdata[11:0];
        end
    end

    // Difference vector, turned into the right half-plane before vectoring.
    always_comb begin
        dx = {i_goal_x[15], i_goal_x} - {i_object_x[15], i_object_x};
        dy = {i_goal_y[15], i_goal_y} - {i_object_y[15], i_object_y};
        sx = {{(VEC_W - 17 - GUARD){dx[16]}}, dx, {GUARD{1'b0}}};
        sy = {{(VEC_W - 17 - GUARD){dy[16]}}, dy, {GUARD{1'b0}}};
        vec_in.zero = (dx == 17'sd0) && (dy == 17'sd0);
        vec_in.gx   = i_goal_x;
        vec_in.gy   = i_goal_y;
        if (dx[16]) begin
            vec_in.x = -sx;
            vec_in.y = -sy;
            vec_in.z = HALF_TURN;
        end else begin
            vec_in.x = sx;
            vec_in.y = sy;
            vec_in.z = '0;
        end
    end

    assign o_ready = vec_en[0];

    for (genvar k = 0; k < STAGES; k++) begin : g_vec
        if (k == STAGES - 1) begin : g_last
            assign vec_en[k] = !vec_v[k] || rot_en[0];
        end else begin : g_mid
            assign vec_en[k] = !vec_v[k] || vec_en[k+1];
        end
        if (k == 0) begin : g_first
            avr_vec_cell #(.STAGE(k)) u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_en    (vec_en[k]),
                .i_valid (i_valid),
                .i_data  (vec_in),
                .o_valid (vec_v[k]),
                .o_data  (vec_q[k])
            );
        end else begin : g_next
            avr_vec_cell #(.STAGE(k)) u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_en    (vec_en[k]),
                .i_valid (vec_v[k-1]),
                .i_data  (vec_q[k-1]),
                .o_valid (vec_v[k]),
                .o_data  (vec_q[k])
            );
        end
    end

    // A zero-length vector has angle zero. Angles beyond a quarter turn are folded back by
    // negating the wing vectors and turning the angle by a half turn.
    always_comb begin
        ang    = vec_q[STAGES-1].zero ? '0 : vec_q[STAGES-1].z;
        flip   = (ang[31:30] == 2'b01) || (ang[31:30] == 2'b10);
        wv     = {{(ROT_W - 12 - GUARD){1'b0}}, r_wing, {GUARD{1'b0}}};
        rot_in.gx = vec_q[STAGES-1].gx;
        rot_in.gy = vec_q[STAGES-1].gy;
        if (flip) begin
            rot_in.ax = wv;
            rot_in.ay = wv;
            rot_in.bx = wv;
            rot_in.by = -wv;
            rot_in.z  = ang + HALF_TURN;
        end else begin
            rot_in.ax = -wv;
            rot_in.ay = -wv;
            rot_in.bx = -wv;
            rot_in.by = wv;
            rot_in.z  = ang;
        end
    end

    for (genvar k = 0; k < STAGES; k++) begin : g_rot
        if (k == STAGES - 1) begin : g_last
            assign rot_en[k] = !rot_v[k] || gain_en;
        end else begin : g_mid
            assign rot_en[k] = !rot_v[k] || rot_en[k+1];
        end
        if (k == 0) begin : g_first
            avr_rot_cell #(.STAGE(k)) u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_en    (rot_en[k]),
                .i_valid (vec_v[STAGES-1]),
                .i_data  (rot_in),
                .o_valid (rot_v[k]),
                .o_data  (rot_q[k])
            );
        end else begin : g_next
            avr_rot_cell #(.STAGE(k)) u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_en    (rot_en[k]),
                .i_valid (rot_v[k-1]),
                .i_data  (rot_q[k-1]),
                .o_valid (rot_v[k]),
                .o_data  (rot_q[k])
            );
        end
    end

    avr_gain u_gain (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (rot_v[STAGES-1]),
        .i_data          (rot_q[STAGES-1]),
        .i_ready         (i_ready),
        .o_en            (gain_en),
        .o_valid         (o_valid),
        .o_first_wing_x  (o_first_wing_x),
        .o_first_wing_y  (o_first_wing_y),
        .o_second_wing_x (o_second_wing_x),
        .o_second_wing_y (o_second_wing_y)
    );

endmodule
